// ----- sv/ucs_pkg.sv -----
// shared types and constants for the ucs-2 little-endian to utf-8 stream converter
package ucs_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStopOnZero = 1'd0;
  localparam logic [CfgIdxW-1:0] RegUnitLimit  = 1'd1;

  // reset values
  localparam logic        StopOnZeroRst = 1'b1;
  localparam logic [15:0] UnitLimitRst  = 16'h0000;

  // encoding thresholds and marks
  localparam logic [15:0] OneByteLim = 16'h0080;
  localparam logic [15:0] TwoByteLim = 16'h0800;
  localparam logic [2:0]  LeadTwo    = 3'b110;   // 0xc0 prefix
  localparam logic [3:0]  LeadThree  = 4'b1110;  // 0xe0 prefix
  localparam logic [1:0]  ContMark   = 2'b10;    // 0x80 prefix

  localparam logic [15:0] CountMax = 16'hFFFF;

  // default queue depth between front and back
  localparam int unsigned QDepthDef = 4;

  // one unit's work, handed from front to back
  typedef struct packed {
    logic [15:0] unit;    // code unit
    logic [1:0]  nbytes;  // utf-8 bytes to send, 0..3
    logic        fin;     // end marker follows the bytes
  } ucs_desc_t;

endpackage

// ----- sv/ucs_if.sv -----
// valid/ready channel interfaces for input bytes and result words
interface ucs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ucs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       string_end;

  modport source (output valid, output utf8_byte, output byte_valid,
                  output last_of_run, output string_end, input ready);
  modport sink   (input valid, input utf8_byte, input byte_valid,
                  input last_of_run, input string_end, output ready);
endinterface

// ----- sv/ucs_front.sv -----
// front end: byte pairing, unit classification, string length tracking
module ucs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ucs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ucs_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          q_full,
  output logic                          q_push,
  output ucs_pkg::ucs_desc_t            q_desc
);

  logic        stop_on_zero_r, stop_on_zero_nxt;
  logic [15:0] unit_limit_r, unit_limit_nxt;
  logic        low_held_r, low_held_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic [15:0] units_seen_r, units_seen_nxt;

  logic        accept;
  logic [15:0] unit;
  logic [15:0] cnt_inc;
  logic        zero_stop;
  logic [1:0]  nbytes;
  logic        fin;

  // a low byte needs no queue room; a high byte may push a descriptor
  assign in_ready = !low_held_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign unit     = {in_byte, low_byte_r};

  always_comb begin
    stop_on_zero_nxt = stop_on_zero_r;
    unit_limit_nxt   = unit_limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ucs_pkg::RegStopOnZero: stop_on_zero_nxt = cfg_wdata[0];
        ucs_pkg::RegUnitLimit:  unit_limit_nxt   = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    zero_stop = (unit == 16'h0000) && stop_on_zero_r;
    if (unit == 16'h0000)                nbytes = 2'd0;
    else if (unit < ucs_pkg::OneByteLim) nbytes = 2'd1;
    else if (unit < ucs_pkg::TwoByteLim) nbytes = 2'd2;
    else                                 nbytes = 2'd3;
    cnt_inc = (units_seen_r == ucs_pkg::CountMax) ? units_seen_r : units_seen_r + 16'd1;
    if (zero_stop) begin
      nbytes = 2'd0;
      fin    = 1'b1;
    end else begin
      fin = (unit_limit_r != 16'h0000) && (cnt_inc >= unit_limit_r);
    end
  end

  always_comb begin
    low_held_nxt   = low_held_r;
    low_byte_nxt   = low_byte_r;
    units_seen_nxt = units_seen_r;
    q_push         = 1'b0;
    if (accept) begin
      if (!low_held_r) begin
        low_held_nxt = 1'b1;
        low_byte_nxt = in_byte;
      end else begin
        low_held_nxt   = 1'b0;
        units_seen_nxt = fin ? 16'h0000 : cnt_inc;
        q_push         = fin || (nbytes != 2'd0);
      end
    end
  end

  assign q_desc = '{unit: unit, nbytes: nbytes, fin: fin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_on_zero_r <= ucs_pkg::StopOnZeroRst;
      unit_limit_r   <= ucs_pkg::UnitLimitRst;
      low_held_r     <= 1'b0;
      units_seen_r   <= 16'h0000;
    end else begin
      stop_on_zero_r <= stop_on_zero_nxt;
      unit_limit_r   <= unit_limit_nxt;
      low_held_r     <= low_held_nxt;
      units_seen_r   <= units_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_byte_r <= low_byte_nxt;
  end

endmodule

// ----- sv/ucs_queue.sv -----
// small descriptor fifo between front and back
module ucs_queue #(
  parameter int unsigned Depth = ucs_pkg::QDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ucs_pkg::ucs_desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output ucs_pkg::ucs_desc_t pop_desc,
  output logic               empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ucs_pkg::ucs_desc_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CntFull);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CntW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule

// ----- sv/ucs_back.sv -----
// back end: descriptor into utf-8 words, one per cycle unless stalled
module ucs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  ucs_pkg::ucs_desc_t q_desc,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         utf8_byte,
  output logic               byte_valid,
  output logic               last_of_run,
  output logic               string_end
);

  ucs_pkg::ucs_desc_t cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       obv_r, obv_nxt;
  logic       olast_r, olast_nxt;

  logic       adv;
  logic [2:0] total;
  logic       is_last;
  logic       is_data;
  logic [7:0] enc;

  assign adv     = !ov_r || out_ready;
  assign total   = {1'b0, cur_r.nbytes} + {2'b00, cur_r.fin};
  assign is_last = ({1'b0, idx_r} == total - 3'd1);
  assign is_data = (idx_r < cur_r.nbytes);

  // byte idx_r of the encoded unit
  always_comb begin
    unique case ({cur_r.nbytes, idx_r})
      {2'd1, 2'd0}: enc = cur_r.unit[7:0];
      {2'd2, 2'd0}: enc = {ucs_pkg::LeadTwo, cur_r.unit[10:6]};
      {2'd2, 2'd1}: enc = {ucs_pkg::ContMark, cur_r.unit[5:0]};
      {2'd3, 2'd0}: enc = {ucs_pkg::LeadThree, cur_r.unit[15:12]};
      {2'd3, 2'd1}: enc = {ucs_pkg::ContMark, cur_r.unit[11:6]};
      {2'd3, 2'd2}: enc = {ucs_pkg::ContMark, cur_r.unit[5:0]};
      default:      enc = 8'h00;
    endcase
  end

  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    obv_nxt   = obv_r;
    olast_nxt = olast_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (busy_r && adv) begin
      ov_nxt    = 1'b1;
      ob_nxt    = is_data ? enc : 8'h00;
      obv_nxt   = is_data;
      olast_nxt = is_last;
      idx_nxt   = idx_r + 2'd1;
      if (is_last) busy_nxt = 1'b0;
    end
    q_pop = !q_empty && (!busy_r || (adv && is_last));
    if (q_pop) begin
      cur_nxt  = q_desc;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    idx_r   <= idx_nxt;
    ob_r    <= ob_nxt;
    obv_r   <= obv_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid   = ov_r;
  assign utf8_byte   = ob_r;
  assign byte_valid  = obv_r;
  assign last_of_run = olast_r;
  assign string_end  = !obv_r;

endmodule

// ----- sv/ucs2_le_to_utf8_stream.sv -----
// top level of the ucs-2 little-endian to utf-8 stream converter
// Converts a stream of bytes, taken in pairs low byte first as 16-bit code
// units, into utf-8 words. A unit below 0x80 gives one byte, below 0x800 two,
// anything else three (surrogate halves are encoded each on its own). A zero
// unit gives no byte; with stop_on_zero set it closes the string, and with
// unit_limit nonzero the string also closes after that many units. A closed
// string is marked by a word with byte_valid low and string_end high, and the
// last word caused by one input byte has last_of_run set. The front end takes
// one input word per cycle while the descriptor queue (QDepth entries) has
// room; a low byte is always taken. The back end drains the queue through a
// registered output stage at one result word per cycle while out_m.ready is
// high. A low byte makes no result word, a high byte up to four (three bytes
// at most plus the end marker). The first result word of a high byte passes
// through the queue and the descriptor register into the output register.
// Configuration is written through cfg_we / cfg_index / cfg_wdata (index 0
// stop_on_zero, index 1 unit_limit) while the stream is idle.
module ucs2_le_to_utf8_stream #(
  parameter int unsigned QDepth = ucs_pkg::QDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ucs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ucs_pkg::CfgDataW-1:0]  cfg_wdata,
  ucs_in_if.sink                        in_s,
  ucs_out_if.source                     out_m
);

  // front to queue
  logic               q_push;
  ucs_pkg::ucs_desc_t q_push_desc;
  logic               q_full;
  // queue to back
  logic               q_pop;
  ucs_pkg::ucs_desc_t q_pop_desc;
  logic               q_empty;

  // pairing, classification and string length tracking
  ucs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .in_byte   (in_s.in_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_push_desc)
  );

  // decouples input acceptance from output backpressure
  ucs_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_desc  (q_pop_desc),
    .empty     (q_empty)
  );

  // expansion to utf-8 words with the end marker appended
  ucs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_desc      (q_pop_desc),
    .q_pop       (q_pop),
    .out_valid   (out_m.valid),
    .out_ready   (out_m.ready),
    .utf8_byte   (out_m.utf8_byte),
    .byte_valid  (out_m.byte_valid),
    .last_of_run (out_m.last_of_run),
    .string_end  (out_m.string_end)
  );

endmodule
